// ===== rtl/bts_pkg.sv =====
// Package for the bilinear texture sampler: sizes, constants and the queue item type.
// Used by every module of the sampler except bts_ram; depends on nothing.
package bts_pkg;

  localparam int MAX_DIM   = 256;
  localparam int DIM_BITS  = $clog2(MAX_DIM);
  localparam int DIM_W     = DIM_BITS + 1;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 18;
  localparam int CFG_IDX_W = 2;
  localparam int BANK_AW   = 2 * (DIM_BITS - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int TEXEL_W   = 24;
  localparam int LERP_W    = 8 + FRAC_BITS;
  localparam int ACC_W     = 8 + 2 * FRAC_BITS;
  localparam int RND_SH    = 2 * FRAC_BITS - 8;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [15:0] WHITE_Q88 = 16'hFF00;
  localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BILINEAR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_PRESENT = 2'd3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                 is_write;
    logic [2*DIM_BITS-1:0] wr_addr;   // {row, col}
    logic [TEXEL_W-1:0]   wr_data;
    logic                 white;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [DIM_BITS-1:0]  x0;
    logic [DIM_BITS-1:0]  x1;
    logic [DIM_BITS-1:0]  y0;
    logic [DIM_BITS-1:0]  y1;
  } bts_item_t;

  function automatic logic [LERP_W-1:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                               input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0] fw;
    fw = ONE_FX - {1'b0, f};
    return LERP_W'(a * fw) + LERP_W'(b * f);
  endfunction

endpackage

// ===== rtl/bts_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bts_front.sv =====
// Front end: configuration registers and classification of incoming items.
// Maps sample coordinates to texel indices and fractions; uses bts_pkg.
module bts_front import bts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 op,
  input  logic [7:0]           texel_col,
  input  logic [7:0]           texel_row,
  input  logic [7:0]           texel_red,
  input  logic [7:0]           texel_green,
  input  logic [7:0]           texel_blue,
  input  logic signed [COORD_W-1:0] coord_u,
  input  logic signed [COORD_W-1:0] coord_v,
  output bts_item_t            item
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             bilinear_r, present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DIM_W'(MAX_DIM);
      height_r   <= DIM_W'(MAX_DIM);
      bilinear_r <= 1'b1;
      present_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TEX_WIDTH:   width_r    <= cfg_data;
        CFG_TEX_HEIGHT:  height_r   <= cfg_data;
        CFG_BILINEAR:    bilinear_r <= cfg_data[0];
        CFG_TEX_PRESENT: present_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]         w_eff, h_eff, wm1, hm1;
  logic                     u_ok, v_ok;
  logic [FRAC_BITS:0]       omv;
  logic [DIM_W+FRAC_BITS-1:0] px;
  logic [DIM_W+FRAC_BITS:0] py;
  logic [DIM_W-1:0]         xi;
  logic [DIM_W:0]           yi;
  logic [DIM_W:0]           x1t, y1t;
  logic [FRAC_BITS-1:0]     fx, fy;

  always_comb begin
    w_eff = (width_r == '0) ? DIM_W'(1) :
            (width_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_r;
    h_eff = (height_r == '0) ? DIM_W'(1) :
            (height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_r;
    wm1 = w_eff - DIM_W'(1);
    hm1 = h_eff - DIM_W'(1);
    // A coordinate is usable only when its sign and integer bits are all zero.
    u_ok = (coord_u[COORD_W-1:FRAC_BITS] == '0);
    v_ok = (coord_v[COORD_W-1:FRAC_BITS] == '0);
    omv  = ONE_FX - {1'b0, coord_v[FRAC_BITS-1:0]};
    px   = w_eff * coord_u[FRAC_BITS-1:0];
    py   = h_eff * omv;
    xi   = px[DIM_W+FRAC_BITS-1:FRAC_BITS];
    yi   = py[DIM_W+FRAC_BITS:FRAC_BITS];
    fx   = px[FRAC_BITS-1:0];
    fy   = py[FRAC_BITS-1:0];
    x1t  = (fx != '0) ? {1'b0, xi} + (DIM_W+1)'(1) : {1'b0, xi};
    y1t  = (fy != '0) ? yi + (DIM_W+1)'(1) : yi;

    item.is_write = (op == OP_WRITE);
    item.wr_addr  = {texel_row, texel_col};
    item.wr_data  = {texel_red, texel_green, texel_blue};
    item.white    = !present_r || !u_ok || !v_ok;
    item.x0 = DIM_BITS'((xi < wm1) ? xi : wm1);
    item.y0 = DIM_BITS'((yi < {1'b0, hm1}) ? yi : {1'b0, hm1});
    // Nearest mode reads only the floor texel, so the ceiling indices follow it.
    item.x1 = !bilinear_r ? item.x0 :
              DIM_BITS'((x1t > {1'b0, wm1}) ? {1'b0, wm1} : x1t);
    item.y1 = !bilinear_r ? item.y0 :
              DIM_BITS'((y1t > {1'b0, hm1}) ? {1'b0, hm1} : y1t);
    // Nearest mode is the blend with both fractions forced to zero.
    item.fx = bilinear_r ? fx : '0;
    item.fy = bilinear_r ? fy : '0;
  end

endmodule

// ===== rtl/bts_queue.sv =====
// Short FIFO of classified items between the front end and the back end.
// Uses bts_pkg for the item type and depth.
module bts_queue import bts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bts_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output bts_item_t head
);

  bts_item_t         slots_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + (Q_PTR_W+1)'(1);
    if (pop && !push) count_nxt = count_r - (Q_PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== rtl/bts_back.sv =====
// Back end: four parity-banked texel memories, two blend stages and the output register.
// Uses bts_pkg and four bts_ram instances.
module bts_back import bts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  bts_item_t   q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red_out,
  output logic [15:0] out_green_out,
  output logic [15:0] out_blue_out,
  output logic        out_defaulted_white
);

  logic adv;
  logic out_valid_r;
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_not_empty;

  // Bank b holds texels whose column parity is b[0] and row parity is b[1].
  logic [TEXEL_W-1:0] bank_dout [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [DIM_BITS-1:0] col, row;
    logic [BANK_AW-1:0]  raddr, waddr;
    logic                we;
    always_comb begin
      col   = (q_head.x0[0] == b[0]) ? q_head.x0 : q_head.x1;
      row   = (q_head.y0[0] == b[1]) ? q_head.y0 : q_head.y1;
      raddr = {row[DIM_BITS-1:1], col[DIM_BITS-1:1]};
      waddr = {q_head.wr_addr[2*DIM_BITS-1:DIM_BITS+1], q_head.wr_addr[DIM_BITS-1:1]};
      we    = q_pop && q_head.is_write &&
              (q_head.wr_addr[0] == b[0]) && (q_head.wr_addr[DIM_BITS] == b[1]);
    end
    bts_ram #(.WIDTH(TEXEL_W), .DEPTH(BANK_DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (q_head.wr_data),
      .re    (adv),
      .raddr (raddr),
      .rdata (bank_dout[b])
    );
  end

  logic                 s1_valid_r, s1_white_r;
  logic [FRAC_BITS-1:0] s1_fx_r, s1_fy_r;
  logic                 s1_x0p_r, s1_x1p_r, s1_y0p_r, s1_y1p_r;
  logic                 s2_valid_r, s2_white_r;
  logic [FRAC_BITS-1:0] s2_fy_r;
  logic [LERP_W-1:0]    s2_lo_r [3];
  logic [LERP_W-1:0]    s2_hi_r [3];
  logic [15:0]          out_chan_r [3];
  logic                 out_white_r;

  logic [TEXEL_W-1:0] t_ll, t_lr, t_ul, t_ur;
  logic [LERP_W-1:0]  lo_nxt [3];
  logic [LERP_W-1:0]  hi_nxt [3];
  logic [15:0]        chan_nxt [3];
  logic [ACC_W-1:0]   acc;
  logic [FRAC_BITS:0] wy;

  always_comb begin
    t_ll = bank_dout[{s1_y0p_r, s1_x0p_r}];
    t_lr = bank_dout[{s1_y0p_r, s1_x1p_r}];
    t_ul = bank_dout[{s1_y1p_r, s1_x0p_r}];
    t_ur = bank_dout[{s1_y1p_r, s1_x1p_r}];
    for (int k = 0; k < 3; k++) begin
      lo_nxt[k] = lerp8(t_ll[23-8*k -: 8], t_lr[23-8*k -: 8], s1_fx_r);
      hi_nxt[k] = lerp8(t_ul[23-8*k -: 8], t_ur[23-8*k -: 8], s1_fx_r);
    end
  end

  always_comb begin
    wy  = ONE_FX - {1'b0, s2_fy_r};
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      acc = ACC_W'(s2_lo_r[k] * wy) + ACC_W'(s2_hi_r[k] * s2_fy_r) +
            (ACC_W'(1) << (RND_SH - 1));
      chan_nxt[k] = s2_white_r ? WHITE_Q88 : acc[RND_SH+15:RND_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_pop && !q_head.is_write;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_white_r <= q_head.white;
      s1_fx_r    <= q_head.fx;
      s1_fy_r    <= q_head.fy;
      s1_x0p_r   <= q_head.x0[0];
      s1_x1p_r   <= q_head.x1[0];
      s1_y0p_r   <= q_head.y0[0];
      s1_y1p_r   <= q_head.y1[0];
      s2_white_r <= s1_white_r;
      s2_fy_r    <= s1_fy_r;
      s2_lo_r    <= lo_nxt;
      s2_hi_r    <= hi_nxt;
      out_chan_r <= chan_nxt;
      out_white_r <= s2_white_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_red_out         = out_chan_r[0];
  assign out_green_out       = out_chan_r[1];
  assign out_blue_out        = out_chan_r[2];
  assign out_defaulted_white = out_white_r;

endmodule

// ===== rtl/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler: front end, item queue and back end.
// Depends on bts_pkg, bts_front, bts_queue, bts_back and bts_ram.
//
//  Channel   Handshake            Payload
//  in_       in_valid/in_ready    op, texel_col/row/red/green/blue, coord_u, coord_v
//  out_      out_valid/out_ready  red_out, green_out, blue_out, defaulted_white
//  cfg_      cfg_wr_en            cfg_index, cfg_data
//
// One item is accepted per cycle while the queue is not full; after its item leaves the queue,
// a sample result is registered in turn by the bank read and two multiply stages.
// Four parity banks serve the four neighbor fetches in the same memory cycle.
// Reset is synchronous and clears control state only; texels are undefined until written.
// An output stall freezes the back end; the four-entry queue keeps taking items until full.
module bilinear_texture_sampler import bts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [7:0]           in_texel_col,
  input  logic [7:0]           in_texel_row,
  input  logic [7:0]           in_texel_red,
  input  logic [7:0]           in_texel_green,
  input  logic [7:0]           in_texel_blue,
  input  logic signed [COORD_W-1:0] in_coord_u,
  input  logic signed [COORD_W-1:0] in_coord_v,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [15:0]          out_red_out,
  output logic [15:0]          out_green_out,
  output logic [15:0]          out_blue_out,
  output logic                 out_defaulted_white
);

  bts_item_t front_item, q_head;
  logic      q_full, q_not_empty, q_pop, q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  bts_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (in_op),
    .texel_col   (in_texel_col),
    .texel_row   (in_texel_row),
    .texel_red   (in_texel_red),
    .texel_green (in_texel_green),
    .texel_blue  (in_texel_blue),
    .coord_u     (in_coord_u),
    .coord_v     (in_coord_v),
    .item        (front_item)
  );

  bts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  bts_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (q_not_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_red_out         (out_red_out),
    .out_green_out       (out_green_out),
    .out_blue_out        (out_blue_out),
    .out_defaulted_white (out_defaulted_white)
  );

  a_white_colors: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_defaulted_white |->
      out_red_out == WHITE_Q88 && out_green_out == WHITE_Q88 && out_blue_out == WHITE_Q88)
    else $error("white default with non-white color");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !q_pop)
    else $error("queue popped during output stall");

  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_pop |=> q_full)
    else $error("full queue drained without a pop");

endmodule

// ===== tb/bilinear_texture_sampler_test.sv =====
// Self-checking testbench for bilinear_texture_sampler: texel writes, samples and size modes.
// Depends on bts_pkg and the RTL of the sampler; a scoreboard class predicts every sample.
module bilinear_texture_sampler_test;
  import bts_pkg::*;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        white;
  } pixel_t;

  class texel_scoreboard;
    logic [23:0] texels [int];
    int          width = 256;
    int          height = 256;
    bit          bilinear = 1;
    bit          present = 0;
    pixel_t      pending [$];
    int          errors = 0;

    function int eff_dim(int d);
      if (d < 1) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
    endfunction

    function bit coord_ok(logic [COORD_W-1:0] c);
      return c[COORD_W-1:FRAC_BITS] == '0;
    endfunction

    // Neighbor indices and fractions of one in-range sample.
    function void footprint(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v,
                            output int x0, output int x1, output int y0, output int y1,
                            output longint fx, output longint fy);
      longint w, h, px, py, xi, yi;
      w = eff_dim(width);
      h = eff_dim(height);
      px = w * longint'(u[FRAC_BITS-1:0]);
      py = h * (65536 - longint'(v[FRAC_BITS-1:0]));
      xi = px >> FRAC_BITS;
      yi = py >> FRAC_BITS;
      fx = px & 65535;
      fy = py & 65535;
      x0 = int'((xi < w - 1) ? xi : w - 1);
      y0 = int'((yi < h - 1) ? yi : h - 1);
      x1 = int'((fx != 0) ? xi + 1 : xi);
      y1 = int'((fy != 0) ? yi + 1 : yi);
      if (x1 > w - 1) x1 = int'(w - 1);
      if (y1 > h - 1) y1 = int'(h - 1);
    endfunction

    function void note_input(logic op, logic [7:0] col, logic [7:0] row, logic [7:0] r,
                             logic [7:0] g, logic [7:0] b,
                             logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
      pixel_t p;
      int x0, x1, y0, y1;
      longint fx, fy, lo, hi, acc;
      logic [23:0] t [4];
      if (op == OP_WRITE) begin
        texels[row * MAX_DIM + col] = {r, g, b};
        return;
      end
      if (!present || !coord_ok(u) || !coord_ok(v)) begin
        p = '{WHITE_Q88, WHITE_Q88, WHITE_Q88, 1'b1};
      end else begin
        footprint(u, v, x0, x1, y0, y1, fx, fy);
        t[0] = texels[y0 * MAX_DIM + x0];
        p.white = 1'b0;
        if (!bilinear) begin
          p.red = {t[0][23:16], 8'h00};
          p.green = {t[0][15:8], 8'h00};
          p.blue = {t[0][7:0], 8'h00};
        end else begin
          t[1] = texels[y0 * MAX_DIM + x1];
          t[2] = texels[y1 * MAX_DIM + x0];
          t[3] = texels[y1 * MAX_DIM + x1];
          for (int k = 0; k < 3; k++) begin
            lo = longint'(t[0][23-8*k -: 8]) * (65536 - fx) + longint'(t[1][23-8*k -: 8]) * fx;
            hi = longint'(t[2][23-8*k -: 8]) * (65536 - fx) + longint'(t[3][23-8*k -: 8]) * fx;
            acc = (lo * (65536 - fy) + hi * fy + (longint'(1) << (RND_SH - 1))) >> RND_SH;
            if (k == 0) p.red = acc[15:0];
            else if (k == 1) p.green = acc[15:0];
            else p.blue = acc[15:0];
          end
        end
      end
      pending.push_back(p);
    endfunction

    function void check_result(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic w);
      pixel_t e;
      if (pending.size() == 0) begin
        $error("result with no sample outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.red) begin
        $error("red_out: expected %0d, got %0d", e.red, r);
        errors++;
      end
      if (g !== e.green) begin
        $error("green_out: expected %0d, got %0d", e.green, g);
        errors++;
      end
      if (b !== e.blue) begin
        $error("blue_out: expected %0d, got %0d", e.blue, b);
        errors++;
      end
      if (w !== e.white) begin
        $error("defaulted_white: expected %0d, got %0d", e.white, w);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;
  logic in_valid, in_ready, in_op;
  logic [7:0] in_texel_col, in_texel_row, in_texel_red, in_texel_green, in_texel_blue;
  logic signed [COORD_W-1:0] in_coord_u, in_coord_v;
  logic out_valid, out_ready;
  logic [15:0] out_red_out, out_green_out, out_blue_out;
  logic out_defaulted_white;

  texel_scoreboard sb;
  bit steady;
  int idle_cycles;

  bilinear_texture_sampler u_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic drive_item(logic op, logic [7:0] col, logic [7:0] row, logic [7:0] r,
                            logic [7:0] g, logic [7:0] b,
                            logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_texel_col = col;
    in_texel_row = row;
    in_texel_red = r;
    in_texel_green = g;
    in_texel_blue = b;
    in_coord_u = u;
    in_coord_v = v;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, col, row, r, g, b, u, v);
    @(negedge clk);
  endtask

  task automatic write_texel(int col, int row);
    drive_item(OP_WRITE, 8'(col), 8'(row), 8'($urandom()), 8'($urandom()), 8'($urandom()),
               COORD_W'($urandom()), COORD_W'($urandom()));
  endtask

  // Texels a non-white sample will read are written first, so its result never uses an unwritten entry.
  task automatic sample(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    int x0, x1, y0, y1;
    longint fx, fy;
    if (sb.present && sb.coord_ok(u) && sb.coord_ok(v)) begin
      sb.footprint(u, v, x0, x1, y0, y1, fx, fy);
      if (!sb.texels.exists(y0 * MAX_DIM + x0)) write_texel(x0, y0);
      if (sb.bilinear) begin
        if (!sb.texels.exists(y0 * MAX_DIM + x1)) write_texel(x1, y0);
        if (!sb.texels.exists(y1 * MAX_DIM + x0)) write_texel(x0, y1);
        if (!sb.texels.exists(y1 * MAX_DIM + x1)) write_texel(x1, y1);
      end
    end
    drive_item(OP_SAMPLE, 8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
               8'($urandom()), u, v);
  endtask

  // Writes cause no result, so the task waits on past the last result to let the queue and the pipeline drain.
  task automatic settle();
    in_valid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_data = DIM_W'(value);
    @(negedge clk);
    cfg_wr_en = 0;
    case (idx)
      CFG_TEX_WIDTH: sb.width = value;
      CFG_TEX_HEIGHT: sb.height = value;
      CFG_BILINEAR: sb.bilinear = value[0];
      default: sb.present = value[0];
    endcase
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 11))
      0: return COORD_W'($urandom());
      1: return COORD_W'(0);
      2: return COORD_W'(65535);
      3: return COORD_W'($urandom_range(65536, 131071));
      default: return COORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int pw [8] = '{1, 256, 256, 0, 511, 5, 37, 200};
    int ph [8] = '{1, 256, 256, 300, 0, 3, 9, 2};
    int pb [8] = '{1, 1, 0, 1, 0, 0, 1, 1};
    int pp [8] = '{1, 1, 1, 1, 1, 1, 1, 0};
    int w;
    sb = new();
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_index = CFG_TEX_WIDTH;
    cfg_data = 0;
    in_valid = 0;
    in_op = OP_WRITE;
    in_texel_col = 0;
    in_texel_row = 0;
    in_texel_red = 0;
    in_texel_green = 0;
    in_texel_blue = 0;
    in_coord_u = 0;
    in_coord_v = 0;
    steady = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // No texture bound after reset: every sample is white.
    sample(18'd32768, 18'd32768);
    sample(0, 0);
    write_texel(255, 255);
    drive_item(OP_WRITE, 0, 0, 8'hFF, 8'h00, 8'hFF, 0, 0);
    settle();
    write_reg(CFG_TEX_WIDTH, 4);
    write_reg(CFG_TEX_HEIGHT, 4);
    write_reg(CFG_TEX_PRESENT, 1);
    sample(0, 0);
    sample(65535, 65535);
    sample(65535, 0);
    sample(0, 65535);
    sample(32768, 32768);
    sample(18'h3FFFF, 100);
    sample(100, 65536);
    sample(18'h1FFFF, 18'h20000);
    sample(18'h20000, 18'h1FFFF);
    settle();
    write_reg(CFG_BILINEAR, 0);
    sample(0, 0);
    sample(49152, 16384);
    sample(65535, 65535);
    settle();

    for (int ph_i = 0; ph_i < 8; ph_i++) begin
      write_reg(CFG_TEX_WIDTH, pw[ph_i]);
      write_reg(CFG_TEX_HEIGHT, ph[ph_i]);
      write_reg(CFG_BILINEAR, pb[ph_i]);
      write_reg(CFG_TEX_PRESENT, pp[ph_i]);
      steady = (ph_i == 2 || ph_i == 5);
      w = sb.eff_dim(pw[ph_i]);
      for (int n = 0; n < 100; n++) begin
        if (n == 50) begin
          in_valid = 0;
          while (sb.pending.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1)) write_texel($urandom_range(0, 255), $urandom_range(0, 255));
          else write_texel($urandom_range(0, w - 1), $urandom_range(0, sb.eff_dim(ph[ph_i]) - 1));
        end else begin
          sample(rand_coord(), rand_coord());
        end
      end
      settle();
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bilinear_texture_sampler: match");
    end else begin
      $display("bilinear_texture_sampler: mismatch");
    end
    $finish;
  end

  // Result side: a random stall before each transaction unless steady is set.
  initial begin
    int stall;
    out_ready = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = pick_gap();
      out_ready = 0;
      repeat (stall) @(negedge clk);
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_red_out, out_green_out, out_blue_out, out_defaulted_white);
      @(negedge clk);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 2000) begin
        $display("bilinear_texture_sampler: mismatch");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
rtl/bts_pkg.sv
rtl/bts_ram.sv
rtl/bts_front.sv
rtl/bts_queue.sv
rtl/bts_back.sv
rtl/bilinear_texture_sampler.sv
tb/bilinear_texture_sampler_test.sv
